// ----- rtl/swst_pkg.sv -----
package swst_pkg;

    // width of a send time stamp and of a sequence number
    localparam int STAMP_W = 32;
    localparam int SEQ_W = 32;

    localparam int WINDOW_DEPTH_DEFAULT = 32;

    localparam int LIMIT_W = 6;
    localparam int TIMEOUT_W = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd20;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd2000;
    localparam logic [SEQ_W-1:0] FIRST_SEQ_RESET = 32'd1;

    typedef enum logic [1:0] {
        REQ_SEND  = 2'd0,
        REQ_ACK   = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_SPARE = 2'd3
    } req_code_t;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_SEQ = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

endpackage

// ----- rtl/swst_stamp_ram.sv -----
module swst_stamp_ram #(
    parameter int DEPTH = swst_pkg::WINDOW_DEPTH_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [ADDR_W-1:0]             waddr,
    input  logic [swst_pkg::STAMP_W-1:0]  wdata,
    input  logic [ADDR_W-1:0]             raddr,
    output logic [swst_pkg::STAMP_W-1:0]  rdata
);

    logic [swst_pkg::STAMP_W-1:0] mem [DEPTH];
    logic [swst_pkg::STAMP_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // write-first: a stamp written this cycle at the read address is seen next cycle
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/sliding_window_sender_tracker.sv -----
// channel   direction  handshake                  payload
// request   in         start & !busy              req_type, ack_number, ack_valid
// result    out        done (one cycle strobe)    send_accepted, assigned_sequence,
//                                                 retransmit, retransmit_sequence,
//                                                 freed_count, outstanding
// config    in         cfg_write                  cfg_index, cfg_data
//
// one request per cycle; its result strobes done after the input register and the result register
// busy is always low: the window state is updated in a single registered pass
// the stamp ram is read at the next head slot every cycle, so the oldest stamp
// is ready in a register when the following tick arrives
// rst_n clears the window state and loads the register reset values; no clearing pass
// the receiver cannot stall: each result is on the ports for exactly one cycle
module sliding_window_sender_tracker #(
    parameter int WINDOW_DEPTH = swst_pkg::WINDOW_DEPTH_DEFAULT,
    parameter int CNT_W = $clog2(WINDOW_DEPTH + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        req_type,
    input  logic [swst_pkg::SEQ_W-1:0]        ack_number,
    input  logic                              ack_valid,

    output logic                              done,
    output logic                              send_accepted,
    output logic [swst_pkg::SEQ_W-1:0]        assigned_sequence,
    output logic                              retransmit,
    output logic [swst_pkg::SEQ_W-1:0]        retransmit_sequence,
    output logic [CNT_W-1:0]                  freed_count,
    output logic [CNT_W-1:0]                  outstanding,

    input  logic                              cfg_write,
    input  logic [swst_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [swst_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int SUM_W = CNT_W + 1;
    localparam int LIM_W = (CNT_W > swst_pkg::LIMIT_W) ? CNT_W : swst_pkg::LIMIT_W;
    localparam int SEQ_W = swst_pkg::SEQ_W;

    // configuration
    logic [swst_pkg::LIMIT_W-1:0]   window_limit_reg;
    logic [swst_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [SEQ_W-1:0]               first_seq_reg;

    // input register
    logic                           in_valid_reg;
    logic [1:0]                     req_reg;
    logic [SEQ_W-1:0]               ack_number_reg;
    logic                           ack_valid_reg;

    // window state
    logic [SLOT_W-1:0]              head_reg, head_next;
    logic [CNT_W-1:0]               in_flight_reg, in_flight_next;
    logic [SEQ_W-1:0]               oldest_reg, oldest_next;
    logic [swst_pkg::STAMP_W-1:0]   time_reg, time_next;

    // result register
    logic                           done_reg;
    logic                           accepted_reg, accepted_next;
    logic [SEQ_W-1:0]               assigned_reg, assigned_next;
    logic                           resend_reg, resend_next;
    logic [SEQ_W-1:0]               resend_seq_reg, resend_seq_next;
    logic [CNT_W-1:0]               freed_reg, freed_next;
    logic [CNT_W-1:0]               outstanding_reg;

    // stamp ram ports
    logic                           ram_we;
    logic [SLOT_W-1:0]              ram_waddr;
    logic [swst_pkg::STAMP_W-1:0]   ram_wdata;
    logic [swst_pkg::STAMP_W-1:0]   head_stamp;

    logic [LIM_W-1:0]               limit_eff;
    logic [SEQ_W-1:0]               ack_diff;
    logic [swst_pkg::STAMP_W-1:0]   age;

    function automatic logic [SLOT_W-1:0] ring_add(
        input logic [SLOT_W-1:0] base,
        input logic [CNT_W-1:0]  offset
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(offset);
        if (sum >= SUM_W'(WINDOW_DEPTH))
        begin
            sum = sum - SUM_W'(WINDOW_DEPTH);
        end
        return sum[SLOT_W-1:0];
    endfunction

    assign busy = 1'b0;

    // window limit saturates at the ring depth
    always_comb
    begin
        if (LIM_W'(window_limit_reg) > LIM_W'(WINDOW_DEPTH))
        begin
            limit_eff = LIM_W'(WINDOW_DEPTH);
        end
        else
        begin
            limit_eff = LIM_W'(window_limit_reg);
        end
    end

    assign ack_diff = ack_number_reg - oldest_reg;
    assign age = time_reg + swst_pkg::STAMP_W'(1) - head_stamp;

    always_comb
    begin
        head_next = head_reg;
        in_flight_next = in_flight_reg;
        oldest_next = oldest_reg;
        time_next = time_reg;
        accepted_next = 1'b0;
        assigned_next = '0;
        resend_next = 1'b0;
        resend_seq_next = '0;
        freed_next = '0;
        ram_we = 1'b0;
        ram_waddr = ring_add(head_reg, in_flight_reg);
        ram_wdata = time_reg;

        if (in_valid_reg)
        begin
            case (req_reg)
                swst_pkg::REQ_SEND:
                begin
                    if (LIM_W'(in_flight_reg) < limit_eff)
                    begin
                        accepted_next = 1'b1;
                        assigned_next = oldest_reg + SEQ_W'(in_flight_reg);
                        ram_we = 1'b1;
                        in_flight_next = in_flight_reg + CNT_W'(1);
                    end
                end
                swst_pkg::REQ_ACK:
                begin
                    if (ack_valid_reg && (in_flight_reg != '0)
                        && (ack_number_reg >= oldest_reg))
                    begin
                        if (ack_diff >= SEQ_W'(in_flight_reg))
                        begin
                            freed_next = in_flight_reg;
                        end
                        else
                        begin
                            freed_next = ack_diff[CNT_W-1:0] + CNT_W'(1);
                        end
                        head_next = ring_add(head_reg, freed_next);
                        oldest_next = oldest_reg + SEQ_W'(freed_next);
                        in_flight_next = in_flight_reg - freed_next;
                    end
                end
                swst_pkg::REQ_TICK:
                begin
                    time_next = time_reg + 32'd1;
                    if ((in_flight_reg != '0)
                        && (age > swst_pkg::STAMP_W'(timeout_reg)))
                    begin
                        resend_next = 1'b1;
                        resend_seq_next = oldest_reg;
                        ram_we = 1'b1;
                        ram_waddr = head_reg;
                        ram_wdata = time_next;
                    end
                end
                default:
                begin
                    // unused code: state holds, only outstanding is reported
                end
            endcase
        end

        // numbering restarts only on an empty window
        if (cfg_write && (cfg_index == swst_pkg::CFG_FIRST_SEQ)
            && (in_flight_reg == '0))
        begin
            oldest_next = cfg_data[SEQ_W-1:0];
        end
    end

    swst_stamp_ram #(
        .DEPTH  (WINDOW_DEPTH),
        .ADDR_W (SLOT_W)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_next),
        .rdata (head_stamp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg <= 1'b0;
            window_limit_reg <= swst_pkg::LIMIT_RESET;
            timeout_reg <= swst_pkg::TIMEOUT_RESET;
            first_seq_reg <= swst_pkg::FIRST_SEQ_RESET;
            head_reg <= '0;
            in_flight_reg <= '0;
            oldest_reg <= swst_pkg::FIRST_SEQ_RESET;
            time_reg <= '0;
        end
        else
        begin
            in_valid_reg <= start;
            done_reg <= in_valid_reg;
            head_reg <= head_next;
            in_flight_reg <= in_flight_next;
            oldest_reg <= oldest_next;
            time_reg <= time_next;

            if (cfg_write)
            begin
                case (cfg_index)
                    swst_pkg::CFG_WINDOW_LIMIT:
                    begin
                        window_limit_reg <= cfg_data[swst_pkg::LIMIT_W-1:0];
                    end
                    swst_pkg::CFG_TIMEOUT:
                    begin
                        timeout_reg <= cfg_data[swst_pkg::TIMEOUT_W-1:0];
                    end
                    swst_pkg::CFG_FIRST_SEQ:
                    begin
                        first_seq_reg <= cfg_data[SEQ_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_reg <= req_type;
            ack_number_reg <= ack_number;
            ack_valid_reg <= ack_valid;
        end
        accepted_reg <= accepted_next;
        assigned_reg <= assigned_next;
        resend_reg <= resend_next;
        resend_seq_reg <= resend_seq_next;
        freed_reg <= freed_next;
        outstanding_reg <= in_flight_next;
    end

    assign done = done_reg;
    assign send_accepted = accepted_reg;
    assign assigned_sequence = assigned_reg;
    assign retransmit = resend_reg;
    assign retransmit_sequence = resend_seq_reg;
    assign freed_count = freed_reg;
    assign outstanding = outstanding_reg;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    localparam int DEPTH = swst_pkg::WINDOW_DEPTH_DEFAULT;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SEQ_W = swst_pkg::SEQ_W;
    localparam int STAMP_W = swst_pkg::STAMP_W;
    localparam int LIMIT_W = swst_pkg::LIMIT_W;
    localparam int TIMEOUT_W = swst_pkg::TIMEOUT_W;
    localparam int CFG_DATA_W = swst_pkg::CFG_DATA_W;
    localparam int CFG_INDEX_W = swst_pkg::CFG_INDEX_W;
    localparam int RAND_PHASES = 24;
    localparam int ITEMS_PER_PHASE = 76;
    localparam int MAX_PRINTED = 20;

    typedef struct packed {
        logic             accepted;
        logic [SEQ_W-1:0] assigned;
        logic             resend;
        logic [SEQ_W-1:0] resend_seq;
        logic [CNT_W-1:0] freed;
        logic [CNT_W-1:0] in_flight;
    } window_result_t;

    typedef struct {
        bit                     is_write;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        swst_pkg::req_code_t    kind;
        logic [SEQ_W-1:0]       ackn;
        logic                   vld;
        bit                     has_fixed;
        window_result_t         fixed;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [1:0]             req_type = swst_pkg::REQ_SEND;
    logic [SEQ_W-1:0]       ack_number = '0;
    logic                   ack_valid = 1'b0;
    logic                   done;
    logic                   send_accepted;
    logic [SEQ_W-1:0]       assigned_sequence;
    logic                   retransmit;
    logic [SEQ_W-1:0]       retransmit_sequence;
    logic [CNT_W-1:0]       freed_count;
    logic [CNT_W-1:0]       outstanding;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // window predictor state
    logic [LIMIT_W-1:0]   limit_q;
    logic [TIMEOUT_W-1:0] timeout_q;
    logic [SEQ_W-1:0]     first_seq_q;
    logic [STAMP_W-1:0]   stamp_q [DEPTH];
    int unsigned          head_q;
    int unsigned          flight_q;
    logic [SEQ_W-1:0]     oldest_q;
    logic [STAMP_W-1:0]   clock_q;

    window_result_t expected_results[$];
    stim_row_t      rows[$];

    bit start_on = 1'b0;
    bit cfg_write_on = 1'b0;
    int n_errors = 0;
    int n_checked = 0;
    int n_requests = 0;
    int n_writes = 0;
    int n_granted = 0;
    int n_refused = 0;
    int n_resends = 0;
    int n_freeing_acks = 0;

    sliding_window_sender_tracker i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .req_type            (req_type),
        .ack_number          (ack_number),
        .ack_valid           (ack_valid),
        .done                (done),
        .send_accepted       (send_accepted),
        .assigned_sequence   (assigned_sequence),
        .retransmit          (retransmit),
        .retransmit_sequence (retransmit_sequence),
        .freed_count         (freed_count),
        .outstanding         (outstanding),
        .cfg_write           (cfg_write),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void reset_window();
        limit_q = swst_pkg::LIMIT_RESET;
        timeout_q = swst_pkg::TIMEOUT_RESET;
        first_seq_q = swst_pkg::FIRST_SEQ_RESET;
        foreach (stamp_q[i])
        begin
            stamp_q[i] = '0;
        end
        head_q = 0;
        flight_q = 0;
        oldest_q = first_seq_q;
        clock_q = '0;
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] value);
        case (idx)
            swst_pkg::CFG_WINDOW_LIMIT: limit_q = value[LIMIT_W-1:0];
            swst_pkg::CFG_TIMEOUT: timeout_q = value[TIMEOUT_W-1:0];
            swst_pkg::CFG_FIRST_SEQ:
            begin
                first_seq_q = value[SEQ_W-1:0];
                // numbering restarts only on an empty window
                if (flight_q == 0)
                    oldest_q = first_seq_q;
            end
            default: ;
        endcase
    endfunction

    function automatic window_result_t step_window(input swst_pkg::req_code_t kind,
                                                   input logic [SEQ_W-1:0] ackn,
                                                   input logic vld);
        window_result_t r;
        int unsigned cap;
        int unsigned n;
        logic [SEQ_W-1:0] span;
        logic [STAMP_W-1:0] age;
        r = '0;
        case (kind)
            swst_pkg::REQ_SEND:
            begin
                cap = (limit_q > DEPTH) ? DEPTH : limit_q;
                if (flight_q < cap)
                begin
                    r.accepted = 1'b1;
                    r.assigned = oldest_q + flight_q;
                    stamp_q[(head_q + flight_q) % DEPTH] = clock_q;
                    flight_q++;
                end
            end
            swst_pkg::REQ_ACK:
            begin
                // plain unsigned compare, no serial-number wrap
                if (vld && flight_q > 0 && ackn >= oldest_q)
                begin
                    span = ackn - oldest_q;
                    n = (span >= flight_q) ? flight_q : span + 1;
                    head_q = (head_q + n) % DEPTH;
                    oldest_q = oldest_q + n;
                    flight_q -= n;
                    r.freed = CNT_W'(n);
                end
            end
            swst_pkg::REQ_TICK:
            begin
                clock_q = clock_q + 1'b1;
                if (flight_q > 0)
                begin
                    age = clock_q - stamp_q[head_q];
                    if (age > timeout_q)
                    begin
                        r.resend = 1'b1;
                        r.resend_seq = oldest_q;
                        stamp_q[head_q] = clock_q;
                    end
                end
            end
            default: ;
        endcase
        r.in_flight = CNT_W'(flight_q);
        return r;
    endfunction

    task automatic report_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTED)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s: got %0h, expected %0h",
                                   n_checked, name, got, want));
    endtask

    always @(posedge clk)
    begin : check_results
        window_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                report_error("result strobe with no request outstanding");
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("send_accepted", 32'(send_accepted), 32'(want.accepted));
                check_field("assigned_sequence", assigned_sequence, want.assigned);
                check_field("retransmit", 32'(retransmit), 32'(want.resend));
                check_field("retransmit_sequence", retransmit_sequence, want.resend_seq);
                check_field("freed_count", 32'(freed_count), 32'(want.freed));
                check_field("outstanding", 32'(outstanding), 32'(want.in_flight));
            end
            n_checked++;
        end
    end

    function automatic void put_write(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] value);
        stim_row_t row;
        row = '{kind: swst_pkg::REQ_SEND, default: '0};
        row.is_write = 1'b1;
        row.reg_index = idx;
        row.reg_value = value;
        rows.insert(rows.size(), row);
    endfunction

    function automatic void put_req(input swst_pkg::req_code_t kind,
                                    input logic [SEQ_W-1:0] ackn,
                                    input logic vld, input bit typed,
                                    input logic acc, input logic [SEQ_W-1:0] seq,
                                    input logic [CNT_W-1:0] freed,
                                    input logic [CNT_W-1:0] flight);
        stim_row_t row;
        row = '{kind: swst_pkg::REQ_SEND, default: '0};
        row.kind = kind;
        row.ackn = ackn;
        row.vld = vld;
        row.has_fixed = typed;
        row.fixed.accepted = acc;
        row.fixed.assigned = seq;
        row.fixed.freed = freed;
        row.fixed.in_flight = flight;
        rows.insert(rows.size(), row);
    endfunction

    task automatic issue(input swst_pkg::req_code_t kind, input logic [SEQ_W-1:0] ackn,
                         input logic vld, input bit has_fixed,
                         input window_result_t fixed);
        window_result_t predicted;
        if (cfg_write_on)
        begin
            cfg_write <= 1'b0;
            cfg_write_on = 1'b0;
        end
        start <= 1'b1;
        req_type <= kind;
        ack_number <= ackn;
        ack_valid <= vld;
        start_on = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = step_window(kind, ackn, vld);
        expected_results.insert(expected_results.size(), has_fixed ? fixed : predicted);
        n_requests++;
        if (kind == swst_pkg::REQ_SEND)
        begin
            if (predicted.accepted)
                n_granted++;
            else
                n_refused++;
        end
        if (predicted.resend)
            n_resends++;
        if (predicted.freed != 0)
            n_freeing_acks++;
    endtask

    task automatic sender_pause(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            start_on = 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        if (start_on)
        begin
            start <= 1'b0;
            start_on = 1'b0;
        end
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        cfg_write_on = 1'b1;
        @(posedge clk);
        apply_reg(idx, value);
        n_writes++;
    endtask

    initial
    begin : stimulus
        int sel;
        int send_pct;
        swst_pkg::req_code_t kind;
        logic [SEQ_W-1:0] ackn;
        logic vld;
        logic [CFG_DATA_W-1:0] word;

        reset_window();

        // default registers: empty-window cases, then a short run
        put_req(swst_pkg::REQ_TICK, '0, 1'b0, 1'b1, 1'b0, '0, '0, '0);
        put_req(swst_pkg::REQ_ACK, 32'd5, 1'b1, 1'b1, 1'b0, '0, '0, '0);
        put_req(swst_pkg::REQ_SPARE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, '0, '0, '0);
        put_req(swst_pkg::REQ_SEND, '0, 1'b0, 1'b1, 1'b1, 32'd1, '0, 6'd1);
        put_req(swst_pkg::REQ_SEND, '0, 1'b0, 1'b1, 1'b1, 32'd2, '0, 6'd2);
        put_req(swst_pkg::REQ_SEND, '0, 1'b0, 1'b1, 1'b1, 32'd3, '0, 6'd3);
        put_req(swst_pkg::REQ_ACK, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, '0, '0, 6'd3);
        put_req(swst_pkg::REQ_ACK, 32'd0, 1'b1, 1'b1, 1'b0, '0, '0, 6'd3);
        put_req(swst_pkg::REQ_ACK, 32'd1, 1'b1, 1'b1, 1'b0, '0, 6'd1, 6'd2);
        put_req(swst_pkg::REQ_ACK, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, '0, 6'd2, '0);
        // zero limit refuses everything
        put_write(swst_pkg::CFG_WINDOW_LIMIT, 32'hFFFF_FFC0);
        put_req(swst_pkg::REQ_SEND, '0, 1'b0, 1'b1, 1'b0, '0, '0, '0);
        // limit above depth, a timeout of one, numbering across the wrap
        put_write(swst_pkg::CFG_WINDOW_LIMIT, 32'h0000_003F);
        put_write(swst_pkg::CFG_TIMEOUT, 32'hFFFF_0001);
        put_write(swst_pkg::CFG_FIRST_SEQ, 32'hFFFF_FFFE);
        put_req(swst_pkg::REQ_SEND, '0, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFE, '0, 6'd1);
        put_req(swst_pkg::REQ_SEND, '0, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, '0, 6'd2);
        put_req(swst_pkg::REQ_SEND, '0, 1'b0, 1'b1, 1'b1, 32'd0, '0, 6'd3);
        put_req(swst_pkg::REQ_TICK, '0, 1'b0, 1'b0, 1'b0, '0, '0, '0);
        put_req(swst_pkg::REQ_TICK, '0, 1'b0, 1'b0, 1'b0, '0, '0, '0);
        put_req(swst_pkg::REQ_ACK, 32'd0, 1'b1, 1'b1, 1'b0, '0, '0, 6'd3);
        put_req(swst_pkg::REQ_ACK, 32'hFFFF_FFFE, 1'b1, 1'b1, 1'b0, '0, 6'd1, 6'd2);
        // first sequence written with packets in flight keeps the numbering
        put_write(swst_pkg::CFG_FIRST_SEQ, 32'd100);
        put_req(swst_pkg::REQ_SEND, '0, 1'b0, 1'b0, 1'b0, '0, '0, '0);
        put_write(swst_pkg::CFG_SPARE, 32'hFFFF_FFFF);
        put_write(swst_pkg::CFG_TIMEOUT, 32'hABCD_FFFF);
        put_req(swst_pkg::REQ_TICK, '0, 1'b0, 1'b0, 1'b0, '0, '0, '0);
        put_req(swst_pkg::REQ_ACK, 32'd5, 1'b1, 1'b0, 1'b0, '0, '0, '0);
        put_req(swst_pkg::REQ_ACK, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, '0, '0, '0);
        put_req(swst_pkg::REQ_ACK, 32'd1, 1'b1, 1'b0, 1'b0, '0, '0, '0);
        put_write(swst_pkg::CFG_FIRST_SEQ, 32'd100);
        put_req(swst_pkg::REQ_SEND, '0, 1'b0, 1'b0, 1'b0, '0, '0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].is_write)
            begin
                wait_idle();
                write_reg(rows[i].reg_index, rows[i].reg_value);
            end
            else
            begin
                issue(rows[i].kind, rows[i].ackn, rows[i].vld, rows[i].has_fixed,
                      rows[i].fixed);
                sender_pause($urandom_range(0, 14));
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_idle();
            // sometimes flush the window so a new first sequence takes effect
            if ($urandom_range(0, 1) == 1)
            begin
                issue(swst_pkg::REQ_ACK, oldest_q + flight_q - 1, 1'b1, 1'b0, '0);
                wait_idle();
            end

            sel = $urandom_range(0, 19);
            word = $urandom;
            if (sel == 0)
                word[LIMIT_W-1:0] = '0;
            else if (sel < 3)
                word[LIMIT_W-1:0] = LIMIT_W'(1);
            else if (sel < 5)
                word[LIMIT_W-1:0] = LIMIT_W'(DEPTH);
            else if (sel < 7)
                word[LIMIT_W-1:0] = LIMIT_W'($urandom_range(DEPTH + 1, 63));
            else
                word[LIMIT_W-1:0] = LIMIT_W'($urandom_range(2, DEPTH - 1));
            write_reg(swst_pkg::CFG_WINDOW_LIMIT, word);

            sel = $urandom_range(0, 9);
            word = $urandom;
            if (sel == 0)
                word[TIMEOUT_W-1:0] = 16'hFFFF;
            else if (sel == 1)
                word[TIMEOUT_W-1:0] = TIMEOUT_W'(1);
            else if (sel == 2)
                word[TIMEOUT_W-1:0] = TIMEOUT_W'($urandom_range(1, 65535));
            else
                word[TIMEOUT_W-1:0] = TIMEOUT_W'($urandom_range(2, 24));
            write_reg(swst_pkg::CFG_TIMEOUT, word);

            if ($urandom_range(0, 1) == 1)
            begin
                sel = $urandom_range(0, 3);
                if (sel == 0)
                    word = '0;
                else if (sel == 1)
                    word = 32'hFFFF_FFFF - $urandom_range(0, 40);
                else if (sel == 2)
                    word = 32'h7FFF_FFF0 + $urandom_range(0, 31);
                else
                    word = $urandom;
                write_reg(swst_pkg::CFG_FIRST_SEQ, word);
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(swst_pkg::CFG_SPARE, $urandom);

            send_pct = $urandom_range(25, 75);
            repeat (ITEMS_PER_PHASE)
            begin
                sel = $urandom_range(0, 99);
                ackn = $urandom;
                vld = 1'($urandom_range(0, 1));
                if (sel < send_pct)
                    kind = swst_pkg::REQ_SEND;
                else if (sel < send_pct + (100 - send_pct) / 2)
                    kind = swst_pkg::REQ_ACK;
                else if (sel < 97)
                    kind = swst_pkg::REQ_TICK;
                else
                    kind = swst_pkg::REQ_SPARE;
                if (kind == swst_pkg::REQ_ACK)
                begin
                    vld = ($urandom_range(0, 7) != 0);
                    case ($urandom_range(0, 3))
                        0: ackn = $urandom;
                        1: ackn = oldest_q + $urandom_range(0, 1);
                        default: ackn = oldest_q + $urandom_range(0, flight_q + 2) - 2;
                    endcase
                end
                issue(kind, ackn, vld, 1'b0, '0);
                sender_pause($urandom_range(0, 14));
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_results.size()));

        $display("%0d requests, %0d results checked, %0d register writes",
                 n_requests, n_checked, n_writes);
        $display("sends granted %0d, refused %0d; resends %0d; acks that freed %0d",
                 n_granted, n_refused, n_resends, n_freeing_acks);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("run timed out with %0d results outstanding", expected_results.size());
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/swst_pkg.sv
rtl/swst_stamp_ram.sv
rtl/sliding_window_sender_tracker.sv
verif/tb_top.sv
